// ===== src/nvrs_pkg.sv =====
// shared types and constants of the n-gram varint record splitter
package nvrs_pkg;

   localparam int unsigned MAX_TOKENS = 15;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned TOKEN_W = 4;
   localparam int unsigned FREQ_W = 15;
   localparam int unsigned SIZE_W = 31;
   localparam int unsigned FILE_W = 15;
   localparam int unsigned LEN_W = 8;
   localparam int unsigned ACC_W = 32;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 31;

   localparam logic [TOKEN_W-1:0] TOKENS_MAX = TOKEN_W'(MAX_TOKENS);
   localparam logic [FILE_W-1:0] LAST_FILE = 15'h7FFF;
   localparam logic [LEN_W-1:0] LEN_MAX = 8'hFF;
   localparam logic [ACC_W-1:0] ACC_SAT = 32'hFFFF_FFFF;
   localparam logic [ACC_W-1:0] ACC_SHIFT_LIMIT = ACC_SAT >> 7;

   localparam logic [TOKEN_W-1:0] TOKENS_RESET = 4'd5;
   localparam logic [SIZE_W-1:0] VOCAB_RESET = 31'h7FFF_FFFF;
   localparam logic [FREQ_W-1:0] MAX_FREQ_RESET = 15'h7FFF;
   localparam logic [SIZE_W-1:0] FILE_LIMIT_RESET = 31'h7FFF_FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOKENS_PER_NGRAM = 2'd0,
      CSR_VOCAB_SIZE       = 2'd1,
      CSR_MAX_FREQ         = 2'd2,
      CSR_FILE_LIMIT       = 2'd3
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_RECORD          = 3'd0,
      KIND_INDEX           = 3'd1,
      KIND_FREQ_RANGE      = 3'd2,
      KIND_UNKNOWN_TOKEN   = 3'd3,
      KIND_TRUNCATED       = 3'd4,
      KIND_FILES_EXHAUSTED = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      PHASE_FREQ   = 3'b001,
      PHASE_TOKENS = 3'b010,
      PHASE_HALT   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [TOKEN_W-1:0] tokens_per_ngram;
      logic [SIZE_W-1:0]  vocab_size;
      logic [FREQ_W-1:0]  max_freq;
      logic [SIZE_W-1:0]  file_limit;
   } cfg_type;

   typedef struct packed {
      logic              done;
      logic              fail;
      kind_type          fail_kind;
      logic [LEN_W-1:0]  len;
      logic [FREQ_W-1:0] freq;
   } parse_event_type;

   typedef struct packed {
      kind_type          kind;
      logic              new_file;
      logic [FILE_W-1:0] file_number;
      logic [SIZE_W-1:0] byte_offset;
      logic [LEN_W-1:0]  record_length;
      logic [FREQ_W-1:0] frequency;
   } rsp_type;

endpackage

// ===== src/nvrs_parser.sv =====
// varint decoder and record framing with range and vocabulary checks
module nvrs_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic [nvrs_pkg::BYTE_W-1:0]      data_byte,
   input  logic                             stream_end,
   input  nvrs_pkg::cfg_type                cfg,
   input  logic                             exhaust,
   output nvrs_pkg::parse_event_type        event_out
);
   import nvrs_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [TOKEN_W-1:0]   tokens_ff, tokens_in;
   logic [LEN_W-1:0]     bytes_ff, bytes_in;
   logic [FREQ_W-1:0]    held_ff, held_in;

   logic [LEN_W-1:0]     bytes_inc;
   logic [ACC_W-1:0]     freq_acc;
   logic [ACC_W-1:0]     tok_acc;
   logic [TOKEN_W-1:0]   need;
   logic [TOKEN_W-1:0]   tokens_inc;
   logic                 more;
   parse_event_type      ev;

   assign bytes_inc = (bytes_ff == LEN_MAX) ? bytes_ff : bytes_ff + LEN_W'(1);
   assign freq_acc = {acc_ff[ACC_W-8:0], data_byte[6:0]};
   assign tok_acc = (acc_ff > ACC_SHIFT_LIMIT) ? ACC_SAT : {acc_ff[ACC_W-8:0], data_byte[6:0]};
   assign more = data_byte[7];
   assign tokens_inc = tokens_ff + TOKEN_W'(1);

   always_comb begin
      priority if (cfg.tokens_per_ngram == '0) begin
         need = TOKEN_W'(1);
      end else if (cfg.tokens_per_ngram > TOKENS_MAX) begin
         need = TOKENS_MAX;
      end else begin
         need = cfg.tokens_per_ngram;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      acc_in = acc_ff;
      tokens_in = tokens_ff;
      bytes_in = bytes_ff;
      held_in = held_ff;
      ev = '{done: 1'b0, fail: 1'b0, fail_kind: KIND_RECORD, len: bytes_inc, freq: held_ff};
      unique case (phase_ff)
         PHASE_FREQ: begin
            priority if (stream_end) begin
               if (bytes_ff != '0) begin
                  ev.fail = 1'b1;
                  ev.fail_kind = KIND_TRUNCATED;
                  ev.len = bytes_ff;
               end
            end else if (freq_acc > ACC_W'(cfg.max_freq)) begin
               ev.fail = 1'b1;
               ev.fail_kind = KIND_FREQ_RANGE;
               ev.freq = '0;
            end else if (more) begin
               acc_in = freq_acc;
               bytes_in = bytes_inc;
            end else if (freq_acc == '0) begin
               ev.done = 1'b1;
               ev.freq = '0;
            end else begin
               held_in = freq_acc[FREQ_W-1:0];
               acc_in = '0;
               tokens_in = '0;
               bytes_in = bytes_inc;
               phase_in = PHASE_TOKENS;
            end
         end
         PHASE_TOKENS: begin
            priority if (stream_end) begin
               ev.fail = 1'b1;
               ev.fail_kind = KIND_TRUNCATED;
               ev.len = bytes_ff;
            end else if (more) begin
               acc_in = tok_acc;
               bytes_in = bytes_inc;
            end else if (tok_acc >= ACC_W'(cfg.vocab_size)) begin
               ev.fail = 1'b1;
               ev.fail_kind = KIND_UNKNOWN_TOKEN;
            end else if (tokens_inc >= need) begin
               ev.done = 1'b1;
            end else begin
               acc_in = '0;
               tokens_in = tokens_inc;
               bytes_in = bytes_inc;
            end
         end
         PHASE_HALT: begin
         end
         default: begin
            phase_in = PHASE_HALT;
         end
      endcase
      // record finished: start the next one
      if (ev.done) begin
         phase_in = PHASE_FREQ;
         acc_in = '0;
         tokens_in = '0;
         bytes_in = '0;
         held_in = '0;
      end
      if (ev.fail || (ev.done && exhaust)) begin
         phase_in = PHASE_HALT;
      end
   end

   assign event_out = ev;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FREQ;
         acc_ff <= '0;
         tokens_ff <= '0;
         bytes_ff <= '0;
         held_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         acc_ff <= acc_in;
         tokens_ff <= tokens_in;
         bytes_ff <= bytes_in;
         held_ff <= held_in;
      end
   end

endmodule

// ===== src/nvrs_placer.sv =====
// output file placement and result formation
module nvrs_placer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  nvrs_pkg::parse_event_type         event_in,
   input  logic [nvrs_pkg::SIZE_W-1:0]       file_limit,
   output logic                              result_valid,
   output nvrs_pkg::rsp_type                 result,
   output logic                              exhaust
);
   import nvrs_pkg::*;

   logic [SIZE_W-1:0] size_ff, size_in;
   logic [FILE_W-1:0] file_ff, file_in;
   logic              open_ff, open_in;

   logic [SIZE_W:0]   sum;
   logic              need_new;
   logic [SIZE_W-1:0] base;
   logic [SIZE_W-1:0] size_len;
   logic [SIZE_W-1:0] size_one;

   assign sum = {1'b0, size_ff} + (SIZE_W + 1)'(event_in.len);
   assign need_new = !open_ff || (sum > {1'b0, file_limit});
   assign exhaust = event_in.done && need_new && open_ff && (file_ff == LAST_FILE);
   assign base = need_new ? '0 : size_ff;
   assign size_len = base + SIZE_W'(event_in.len);
   assign size_one = base + SIZE_W'(1);

   always_comb begin
      size_in = size_ff;
      file_in = file_ff;
      open_in = open_ff;
      result_valid = event_in.done || event_in.fail;
      result = '{kind: event_in.fail_kind, new_file: 1'b0, file_number: file_ff,
                 byte_offset: size_ff, record_length: event_in.len,
                 frequency: event_in.freq};
      priority if (event_in.fail) begin
      end else if (exhaust) begin
         result.kind = KIND_FILES_EXHAUSTED;
      end else if (event_in.done) begin
         if (need_new) begin
            file_in = open_ff ? file_ff + FILE_W'(1) : '0;
            open_in = 1'b1;
         end
         result.new_file = need_new;
         result.file_number = file_in;
         if (event_in.freq == '0) begin
            result.kind = KIND_INDEX;
            result.byte_offset = size_one;
            size_in = size_one;
         end else begin
            result.kind = KIND_RECORD;
            result.byte_offset = base;
            size_in = size_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
         file_ff <= '0;
         open_ff <= 1'b0;
      end else if (step) begin
         size_ff <= size_in;
         file_ff <= file_in;
         open_ff <= open_in;
      end
   end

endmodule

// ===== src/ngram_varint_record_splitter.sv =====
// top level: request register, parser, placer, result register and csr file
// Takes one stream byte per request and sustains one request per clock while
// no result waits on rsp_ready. A request is held in the input register; as
// it advances, the parser and placer update their state and any result is
// loaded into the result register. The cycle is set by the per-byte update:
// the 32-bit varint shift-add with its vocabulary compare, and the file size
// add-compare of the placer. A new request is taken while an earlier result
// still waits on rsp_ready. After any error the block reports it once and
// ignores all requests until reset. The user must write configuration through
// csr_we/csr_index/csr_wdata only while idle; the block does not enforce it.
module ngram_varint_record_splitter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [nvrs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [nvrs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [nvrs_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic                                req_stream_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [nvrs_pkg::KIND_W-1:0]         rsp_kind,
   output logic                                rsp_new_file,
   output logic [nvrs_pkg::FILE_W-1:0]         rsp_file_number,
   output logic [nvrs_pkg::SIZE_W-1:0]         rsp_byte_offset,
   output logic [nvrs_pkg::LEN_W-1:0]          rsp_record_length,
   output logic [nvrs_pkg::FREQ_W-1:0]         rsp_frequency
);
   import nvrs_pkg::*;

   cfg_type             cfg_ff;
   logic                in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]   byte_ff;
   logic                end_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff;

   logic                advance;
   logic                exhaust;
   parse_event_type     ev;
   logic                res_valid;
   rsp_type             res;

   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      priority if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      priority if (advance && res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_data_byte;
         end_ff <= req_stream_end;
      end
      if (advance && res_valid) begin
         rsp_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tokens_per_ngram <= TOKENS_RESET;
         cfg_ff.vocab_size <= VOCAB_RESET;
         cfg_ff.max_freq <= MAX_FREQ_RESET;
         cfg_ff.file_limit <= FILE_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_TOKENS_PER_NGRAM: cfg_ff.tokens_per_ngram <= csr_wdata[TOKEN_W-1:0];
            CSR_VOCAB_SIZE:       cfg_ff.vocab_size <= csr_wdata[SIZE_W-1:0];
            CSR_MAX_FREQ:         cfg_ff.max_freq <= csr_wdata[FREQ_W-1:0];
            CSR_FILE_LIMIT:       cfg_ff.file_limit <= csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   nvrs_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .data_byte  (byte_ff),
      .stream_end (end_ff),
      .cfg        (cfg_ff),
      .exhaust    (exhaust),
      .event_out  (ev)
   );

   nvrs_placer u_placer (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .event_in      (ev),
      .file_limit    (cfg_ff.file_limit),
      .result_valid  (res_valid),
      .result        (res),
      .exhaust       (exhaust)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_ff.kind;
   assign rsp_new_file = rsp_ff.new_file;
   assign rsp_file_number = rsp_ff.file_number;
   assign rsp_byte_offset = rsp_ff.byte_offset;
   assign rsp_record_length = rsp_ff.record_length;
   assign rsp_frequency = rsp_ff.frequency;

endmodule
